// ----- hw/rtl/fwrl_pkg.sv -----
// ----------------------------------------------------------------------------
// fwrl_pkg: shared types and constants for the fixed-window rate limiter
// Table geometry, register reset values, outcome codes and beat structs.
// ----------------------------------------------------------------------------
package fwrl_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [15:0] WINDOW_RESET = 16'd60;
  localparam logic [7:0]  MAX_RESET    = 8'd10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd1;

  typedef enum logic [2:0] {
    OUT_NEW        = 3'd0,
    OUT_COUNTED    = 3'd1,
    OUT_NEW_WINDOW = 3'd2,
    OUT_REFUSED    = 3'd3,
    OUT_FULL       = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic       allowed;
    logic [2:0] outcome;
  } rsp_t;

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  count;
    logic [31:0] win_begin;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch request, reset scan
    logic scan;    // issue a table read at the scan pointer
    logic commit;  // decide, update table, load result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // scan pointer at last entry
    logic out_free;   // result register can take a new beat
  } status_t;

endpackage

// ----- hw/rtl/fwrl_ctrl.sv -----
// ----------------------------------------------------------------------------
// fwrl_ctrl: sequencer for the rate limiter
// Steps one request through accept, table scan, drain and commit.
// ----------------------------------------------------------------------------
module fwrl_ctrl import fwrl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t state;

  // Decode commands from the current state
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.start = in_valid;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_DRAIN: begin
      end
      S_DECIDE: begin
        cmd.commit = status.out_free;
      end
      default: begin
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (status.scan_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/fwrl_dp.sv -----
// ----------------------------------------------------------------------------
// fwrl_dp: datapath for the rate limiter
// Source table memory, valid bits, scan comparator, decision and result beat.
// ----------------------------------------------------------------------------
module fwrl_dp import fwrl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  req_t                 in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rsp_t                 out_data
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data;
  logic [TABLE_ENTRIES-1:0] valid;

  logic [15:0] window_seconds;
  logic [7:0]  request_cap;

  req_t             req;
  logic [IDX_W-1:0] ptr;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;

  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [7:0]       hit_count;
  logic [31:0]      hit_start;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_data;
  rsp_t             rsp_next;
  logic [31:0]      age;
  logic             chk_hit;
  logic             chk_free;

  assign status.scan_last = (ptr == IDX_W'(TABLE_ENTRIES - 1));
  assign status.out_free  = !out_valid || !out_stall;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= WINDOW_RESET;
      request_cap    <= MAX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW: window_seconds <= cfg_data;
        REG_MAX:    request_cap    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Table memory: one write port, one registered read port at the scan pointer
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    rd_data <= mem[ptr];
  end

  // Compare the entry read last cycle against the request
  assign chk_hit  = chk_vld && valid[chk_idx] && (rd_data.address == req.source_address);
  assign chk_free = chk_vld && !valid[chk_idx];

  // Scan pointer, compare stage and search results
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      chk_vld <= cmd.scan;
      if (cmd.start) begin
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (chk_hit && !hit_found) hit_found <= 1'b1;
        if (chk_free && !free_found) free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= in_data;
      ptr <= '0;
    end else if (cmd.scan) begin
      ptr <= ptr + 1'b1;
    end
    chk_idx <= ptr;
    if (!cmd.start && chk_hit && !hit_found) begin
      hit_idx   <= chk_idx;
      hit_count <= rd_data.count;
      hit_start <= rd_data.win_begin;
    end
    if (!cmd.start && chk_free && !free_found) free_idx <= chk_idx;
  end

  // Decide the outcome and the table update
  assign age = req.now_seconds - hit_start;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = hit_idx;
    wr_data = '{address: req.source_address, count: 8'd1, win_begin: req.now_seconds};
    rsp_next = '{allowed: 1'b1, outcome: OUT_FULL};
    if (hit_found) begin
      if (age >= {16'd0, window_seconds}) begin
        wr_en = cmd.commit;
        rsp_next.outcome = OUT_NEW_WINDOW;
      end else if (hit_count < request_cap) begin
        wr_en = cmd.commit;
        wr_data.count = hit_count + 8'd1;
        wr_data.win_begin = hit_start;
        rsp_next.outcome = OUT_COUNTED;
      end else begin
        rsp_next = '{allowed: 1'b0, outcome: OUT_REFUSED};
      end
    end else if (free_found) begin
      wr_en  = cmd.commit;
      wr_idx = free_idx;
      rsp_next.outcome = OUT_NEW;
    end
  end

  // Mark entries taken by new sources
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.commit && !hit_found && free_found) begin
      valid[free_idx] <= 1'b1;
    end
  end

  // Result register: load on commit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_data <= rsp_next;
  end

endmodule

// ----- hw/rtl/per_source_fixed_window_rate_limiter_top.sv -----
// ----------------------------------------------------------------------------
// per_source_fixed_window_rate_limiter_top: per-source request rate limiter
// Tracks up to TABLE_ENTRIES sources, each with a count and window start.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_data) carries one request beat: source
//   address and current time in seconds. out channel (out_valid/out_stall/
//   out_data) returns one beat per request: allowed flag and outcome code.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the window
//   length (index 0) and the per-window request limit (index 1); write only
//   while idle. cfg_ready is always high.
//   From accept to result, one comparator walks the table through a single
//   registered memory read port, then a commit step updates the entry.
//   The next request is accepted only after the previous one is done;
//   in_stall stays high from accept until the result is loaded.
//   A result waiting under out_stall does not block the next request; that
//   request scans normally and holds at commit until the result register frees.
//   Reset clears all valid marks at once and restores the register defaults.
// ----------------------------------------------------------------------------
module per_source_fixed_window_rate_limiter_top import fwrl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rsp_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  fwrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fwrl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // Busy after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but block not busy");

  // Only a refused request is denied
  a_allowed_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.allowed == (out_data.outcome != OUT_REFUSED)))
    else $error("allowed flag disagrees with outcome");

  // A new result is loaded only while a request is in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no request in progress");
`endif

endmodule

// ----- dv/per_source_fixed_window_rate_limiter_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_fixed_window_rate_limiter_top_test: rate limiter self-checking bench
// Keeps its own copy of the source table and both registers and predicts the
// verdict for every request beat taken. Directed requests cover the boundary
// cases, then bursts of requests per source run under several register
// settings and idle patterns. Each verdict beat is checked against the
// oldest prediction.
// ----------------------------------------------------------------------------
module per_source_fixed_window_rate_limiter_top_test;
  import fwrl_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  req_t                 in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rsp_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  per_source_fixed_window_rate_limiter_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the limiter: source table and registers
  bit        tbl_valid [TABLE_ENTRIES];
  bit [31:0] tbl_addr  [TABLE_ENTRIES];
  bit [7:0]  tbl_count [TABLE_ENTRIES];
  bit [31:0] tbl_start [TABLE_ENTRIES];
  bit [15:0] win_len   = WINDOW_RESET;
  bit [7:0]  req_limit = MAX_RESET;

  req_t requests_pending[$];
  rsp_t verdicts_due[$];
  int   mismatches = 0;
  bit   in_took = 1'b0;

  // Idle percentages for the request sender and the verdict receiver
  int send_gap_pct = 0;
  int recv_hold_pct = 0;

  // Stimulus-side view of time, sources and register values
  bit [31:0] wall = '0;
  bit [31:0] known_src [40];
  int        win_now = WINDOW_RESET;

  // Look up the source, update its entry and return the verdict
  function automatic rsp_t police_request(req_t r);
    int        hit = -1;
    int        spare = -1;
    bit [31:0] age;
    rsp_t      v;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (hit < 0 && tbl_addr[i] == r.source_address) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (hit >= 0) begin
      age = r.now_seconds - tbl_start[hit];
      if (age >= {16'd0, win_len}) begin
        tbl_count[hit] = 8'd1;
        tbl_start[hit] = r.now_seconds;
        v.allowed = 1'b1;
        v.outcome = OUT_NEW_WINDOW;
      end else if (tbl_count[hit] < req_limit) begin
        tbl_count[hit] = tbl_count[hit] + 8'd1;
        v.allowed = 1'b1;
        v.outcome = OUT_COUNTED;
      end else begin
        v.allowed = 1'b0;
        v.outcome = OUT_REFUSED;
      end
    end else if (spare >= 0) begin
      tbl_valid[spare] = 1'b1;
      tbl_addr[spare]  = r.source_address;
      tbl_count[spare] = 8'd1;
      tbl_start[spare] = r.now_seconds;
      v.allowed = 1'b1;
      v.outcome = OUT_NEW;
    end else begin
      v.allowed = 1'b1;
      v.outcome = OUT_FULL;
    end
    return v;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (mismatches < 40)
      $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Check verdict beats, predict accepted requests, track register writes
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch("verdict beat with no request pending", out_data.outcome, 0);
        end else begin
          want = verdicts_due.pop_front();
          if (out_data.allowed !== want.allowed)
            flag_mismatch("allowed", out_data.allowed, want.allowed);
          if (out_data.outcome !== want.outcome)
            flag_mismatch("outcome", out_data.outcome, want.outcome);
        end
      end
      if (in_valid && !in_stall)
        verdicts_due.push_back(police_request(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW: win_len = cfg_data;
          REG_MAX:    req_limit = cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Request driver: advance after each taken beat, hold otherwise
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (requests_pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_data  <= requests_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Verdict receiver: stall at random
  always @(negedge clk) begin
    out_stall <= (recv_hold_pct != 0) && ($urandom_range(99) < recv_hold_pct);
  end

  task automatic push_req(bit [31:0] src, bit [31:0] t);
    req_t r;
    r.source_address = src;
    r.now_seconds    = t;
    requests_pending.push_back(r);
  endtask

  // Queue bursts from one source with small time steps, window jumps and noise
  task automatic queue_bursts(int n, int burst_cap);
    int        made = 0;
    int        len;
    int        roll;
    bit [31:0] src;
    while (made < n) begin
      if ($urandom_range(99) < 15) src = $urandom();
      else src = known_src[$urandom_range(39)];
      len = $urandom_range(1, burst_cap);
      for (int k = 0; k < len && made < n; k++) begin
        roll = $urandom_range(99);
        if (roll < 2) wall = $urandom();
        else if (roll < 7) wall += win_now + $urandom_range(0, 3);
        else wall += $urandom_range(0, 2);
        if ($urandom_range(99) < 4) push_req($urandom(), wall);
        else push_req(src, wall);
        made++;
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request is taken and every verdict is back, then settle
  task automatic drain();
    while (requests_pending.size() != 0 || in_valid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
  endtask

  initial begin
    known_src[0] = 32'h0000_0000;
    known_src[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 40; i++) known_src[i] = $urandom();
    send_gap_pct  = 11;
    recv_hold_pct = 56;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, wrap of time, window boundary, limit reached
    push_req(32'h0000_0000, 32'h0000_0000);
    push_req(32'hFFFF_FFFF, 32'hFFFF_FFF0);
    push_req(32'hFFFF_FFFF, 32'h0000_0010);
    push_req(32'hFFFF_FFFF, 32'h0000_002C);
    push_req(32'h0000_0000, 32'd59);
    for (int i = 0; i < 9; i++) push_req(32'h0000_0000, 32'd59);
    push_req(32'h8000_0000, 32'h7FFF_FFFF);
    push_req(32'h7FFF_FFFF, 32'hAAAA_AAAA);
    push_req(32'h5555_5555, 32'h5555_5555);
    drain();

    // Short window, low limit
    write_reg(REG_WINDOW, 16'd5);
    write_reg(REG_MAX, 16'd3);
    win_now = 5;
    queue_bursts(190, 6);
    drain();

    // Largest window and limit: run one source up to the count ceiling
    send_gap_pct  = 56;
    recv_hold_pct = 11;
    write_reg(REG_WINDOW, 16'hFFFF);
    write_reg(REG_MAX, 16'h00FF);
    win_now = 65535;
    for (int i = 0; i < 258; i++) begin
      wall += $urandom_range(0, 1);
      push_req(32'h0000_0000, wall);
    end
    queue_bursts(60, 30);
    drain();

    // Zero window and zero limit; writes to unused indexes are dropped
    write_reg(2'd3, 16'h0007);
    write_reg(2'd2, 16'hFFFF);
    write_reg(REG_WINDOW, 16'h0000);
    write_reg(REG_MAX, 16'hAB00);
    win_now = 0;
    queue_bursts(140, 4);
    drain();

    // Smallest nonzero settings, no idling from here on
    send_gap_pct  = 0;
    recv_hold_pct = 0;
    write_reg(REG_WINDOW, 16'd1);
    write_reg(REG_MAX, 16'd1);
    win_now = 1;
    queue_bursts(140, 4);
    drain();

    write_reg(REG_WINDOW, 16'd20);
    write_reg(REG_MAX, 16'd6);
    win_now = 20;
    queue_bursts(140, 9);
    drain();

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("per_source_fixed_window_rate_limiter_top: match");
    end else begin
      $display("per_source_fixed_window_rate_limiter_top: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("per_source_fixed_window_rate_limiter_top: mismatch");
    $finish;
  end

endmodule
